### rtl/wks_pkg.sv
// Shared types and constants for the weighted key selector with health tracking.
// Used by wks_ctrl, wks_datapath and the top level; depends on nothing.
`default_nettype none

package wks_pkg;

  // running weight: 13-bit two's complement, saturating
  localparam int RW_W = 13;
  // sum of healthy weights: at most 8 * 255
  localparam int TOTAL_W = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic signed [RW_W-1:0] RW_MAX = {1'b0, {(RW_W-1){1'b1}}};
  localparam logic signed [RW_W-1:0] RW_MIN = {1'b1, {(RW_W-1){1'b0}}};

  typedef enum logic [1:0] {
    FUNC_PICK    = 2'd0,
    FUNC_SUCCESS = 2'd1,
    FUNC_FAILURE = 2'd2,
    FUNC_TICK    = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WEIGHT_TABLE   = 2'd0,
    CFG_TARGETS_IN_USE = 2'd1,
    CFG_FAILURE_LIMIT  = 2'd2,
    CFG_COOLDOWN_TICKS = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ADJUST,
    ST_APPLY,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic latch;   // take the accepted item
    logic scan;    // visit one target of a pick
    logic adjust;  // subtract the total from the winner
    logic apply;   // report or tick update
    logic finish;  // load the result register
  } cmd_t;

  typedef struct packed {
    logic in_pick;    // item on the input is a pick
    logic scan_last;  // scan sits on the last target
    logic out_free;   // result register can take a new item
  } status_t;

  function automatic logic signed [RW_W-1:0] sat_rw(input logic signed [RW_W:0] v);
    logic signed [RW_W:0] hi;
    logic signed [RW_W:0] lo;
    hi = {RW_MAX[RW_W-1], RW_MAX};
    lo = {RW_MIN[RW_W-1], RW_MIN};
    if (v > hi) begin
      return RW_MAX;
    end else if (v < lo) begin
      return RW_MIN;
    end else begin
      return $signed(v[RW_W-1:0]);
    end
  endfunction

endpackage

`default_nettype wire

### rtl/wks_ctrl.sv
// Controller state machine of the weighted key selector.
// Drives datapath commands from datapath status; uses wks_pkg.
`default_nettype none

module wks_ctrl
  import wks_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = status.in_pick ? ST_SCAN : ST_APPLY;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_next = ST_ADJUST;
        end
      end
      ST_ADJUST: state_next = ST_FINISH;
      ST_APPLY:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    cmd.latch     = (state == ST_IDLE) && s_axis_tvalid;
    cmd.scan      = (state == ST_SCAN);
    cmd.adjust    = (state == ST_ADJUST);
    cmd.apply     = (state == ST_APPLY);
    cmd.finish    = (state == ST_FINISH) && status.out_free;
  end

`ifndef NO_ASSERTIONS
  a_scan_to_adjust: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && status.scan_last) |=> (state == ST_ADJUST))
    else $error("scan did not end in the adjust step");
  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && !status.out_free) |=> (state == ST_FINISH && !s_axis_tready))
    else $error("result dropped while the output was stalled");
`endif

endmodule

`default_nettype wire

### rtl/wks_datapath.sv
// Datapath of the weighted key selector: configuration, per-target state,
// one-target-per-cycle scan and the result register. Uses wks_pkg.
`default_nettype none

module wks_datapath
  import wks_pkg::*;
#(
  parameter int NUM_TARGETS   = 8,
  parameter int WEIGHT_BITS   = 8,
  parameter int COOLDOWN_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [7:0]            s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [7:0]                 m_axis_tdata,
  input  wire cmd_t                  cmd,
  output status_t                    status
);

  localparam int IDX_W = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
  localparam int CD_COPY = (COOLDOWN_BITS < 16) ? COOLDOWN_BITS : 16;
  localparam logic [7:0] WMASK = 8'((16'd1 << WEIGHT_BITS) - 16'd1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TARGETS - 1);

  // configuration
  logic [63:0] weight_table;
  logic [3:0]  targets_in_use;
  logic [7:0]  failure_limit;
  logic [15:0] cooldown_ticks;

  // per-target state
  logic signed [RW_W-1:0]  running_weight [NUM_TARGETS];
  logic                    healthy_flag   [NUM_TARGETS];
  logic [7:0]              failure_count  [NUM_TARGETS];
  logic [COOLDOWN_BITS-1:0] cooldown_left [NUM_TARGETS];

  // item registers
  func_t                  func_q;
  logic [2:0]             id_q;
  logic [IDX_W-1:0]       scan_idx;
  logic [TOTAL_W-1:0]     total;
  logic                   found;
  logic [IDX_W-1:0]       best_idx;
  logic signed [RW_W-1:0] best_val;
  logic [2:0]             picked_q;
  logic                   none_q;
  logic [3:0]             count_q;

  logic [3:0]               n_used;
  logic [IDX_W-1:0]         addr;
  logic                     addr_in_use;
  logic                     id_in_use;
  logic signed [RW_W-1:0]   rw_a;
  logic                     h_a;
  logic [7:0]               fc_a;
  logic [COOLDOWN_BITS-1:0] cd_a;
  logic [7:0]               w_raw;
  logic [7:0]               w;
  logic                     revive;
  logic signed [RW_W-1:0]   rw_base;
  logic signed [RW_W-1:0]   rw_sum;
  logic signed [RW_W-1:0]   rw_sub;
  logic [7:0]               fc_inc;
  logic [COOLDOWN_BITS-1:0] cd_load;
  logic [3:0]               healthy_cnt;

  logic                     rw_we;
  logic signed [RW_W-1:0]   rw_wdata;
  logic                     h_we;
  logic                     h_wdata;
  logic                     fc_we;
  logic [7:0]               fc_wdata;
  logic                     cd_we;
  logic                     tick_all;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_table   <= '0;
      targets_in_use <= 4'd8;
      failure_limit  <= 8'd3;
      cooldown_ticks <= 16'd60;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WEIGHT_TABLE:   weight_table   <= cfg_data;
        CFG_TARGETS_IN_USE: targets_in_use <= cfg_data[3:0];
        CFG_FAILURE_LIMIT:  failure_limit  <= cfg_data[7:0];
        CFG_COOLDOWN_TICKS: cooldown_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    n_used = (targets_in_use > 4'(NUM_TARGETS)) ? 4'(NUM_TARGETS) : targets_in_use;
    cd_load = '0;
    cd_load[CD_COPY-1:0] = cooldown_ticks[CD_COPY-1:0];
  end

  // one shared read address: scan position, winner, or reported target
  always_comb begin
    if (cmd.adjust) begin
      addr = best_idx;
    end else if (cmd.apply) begin
      addr = id_q[IDX_W-1:0];
    end else begin
      addr = scan_idx;
    end
    addr_in_use = (4'(addr) < n_used);
    id_in_use   = ({1'b0, id_q} < n_used);
    rw_a = running_weight[addr];
    h_a  = healthy_flag[addr];
    fc_a = failure_count[addr];
    cd_a = cooldown_left[addr];
    w_raw = weight_table[{addr, 3'b000} +: 8] & WMASK;
    w     = (w_raw == 8'd0) ? 8'd1 : w_raw;
    revive  = addr_in_use && !h_a && (cd_a == '0);
    rw_base = revive ? '0 : rw_a;
    rw_sum  = sat_rw($signed({rw_base[RW_W-1], rw_base}) + $signed({6'd0, w}));
    rw_sub  = sat_rw($signed({rw_a[RW_W-1], rw_a}) - $signed({2'd0, total}));
    fc_inc  = (fc_a == 8'hFF) ? fc_a : fc_a + 8'd1;
  end

  always_comb begin
    rw_we    = 1'b0;
    rw_wdata = rw_sum;
    h_we     = 1'b0;
    h_wdata  = 1'b1;
    fc_we    = 1'b0;
    fc_wdata = 8'd0;
    cd_we    = 1'b0;
    tick_all = 1'b0;
    if (cmd.scan) begin
      rw_we = addr_in_use && (h_a || revive);
      h_we  = revive;
      fc_we = revive;
    end else if (cmd.adjust) begin
      rw_we    = found;
      rw_wdata = rw_sub;
    end else if (cmd.apply) begin
      case (func_q)
        FUNC_SUCCESS: begin
          h_we  = id_in_use;
          fc_we = id_in_use;
        end
        FUNC_FAILURE: begin
          fc_we    = id_in_use;
          fc_wdata = fc_inc;
          // mark unhealthy and restart the cooldown at the limit
          h_we     = id_in_use && (fc_inc >= failure_limit);
          h_wdata  = 1'b0;
          cd_we    = id_in_use && (fc_inc >= failure_limit);
        end
        FUNC_TICK: tick_all = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TARGETS; i++) begin
        running_weight[i] <= '0;
        healthy_flag[i]   <= 1'b1;
        failure_count[i]  <= '0;
        cooldown_left[i]  <= '0;
      end
    end else begin
      if (rw_we) running_weight[addr] <= rw_wdata;
      if (h_we)  healthy_flag[addr]   <= h_wdata;
      if (fc_we) failure_count[addr]  <= fc_wdata;
      if (cd_we) cooldown_left[addr]  <= cd_load;
      if (tick_all) begin
        for (int i = 0; i < NUM_TARGETS; i++) begin
          if (cooldown_left[i] != '0) begin
            cooldown_left[i] <= cooldown_left[i] - COOLDOWN_BITS'(1);
          end
        end
      end
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q   <= func_t'(s_axis_tdata[1:0]);
      id_q     <= s_axis_tdata[4:2];
      scan_idx <= '0;
      total    <= '0;
      found    <= 1'b0;
      best_idx <= '0;
      best_val <= '0;
    end else if (cmd.scan) begin
      if (scan_idx != LAST_IDX) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (addr_in_use && (h_a || revive)) begin
        total <= total + TOTAL_W'(w);
        if (!found || (rw_sum > best_val)) begin
          found    <= 1'b1;
          best_idx <= addr;
          best_val <= rw_sum;
        end
      end
    end
  end

  always_comb begin
    healthy_cnt = '0;
    for (int i = 0; i < NUM_TARGETS; i++) begin
      if (healthy_flag[i] && (4'(i) < n_used)) begin
        healthy_cnt = healthy_cnt + 4'd1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      picked_q <= (func_q == FUNC_PICK && found) ? 3'(best_idx) : 3'd0;
      none_q   <= (func_q == FUNC_PICK) && !found;
      count_q  <= healthy_cnt;
    end
  end

  assign m_axis_tdata = {count_q, none_q, picked_q};

  always_comb begin
    status.in_pick   = (func_t'(s_axis_tdata[1:0]) == FUNC_PICK);
    status.scan_last = (scan_idx == LAST_IDX);
    status.out_free  = !m_axis_tvalid || m_axis_tready;
  end

`ifndef NO_ASSERTIONS
  a_none_means_no_healthy: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && func_q == FUNC_PICK && !found) |=> (count_q == 4'd0 && none_q))
    else $error("pick found nothing while targets were healthy");
  a_winner_in_use: assert property (@(posedge clk) disable iff (rst)
    (cmd.adjust && found) |-> (4'(best_idx) < n_used))
    else $error("winner lies outside the targets in use");
`endif

endmodule

`default_nettype wire

### rtl/weighted_key_selector_with_health.sv
// Weighted key selector with health tracking: top level.
// Instantiates wks_ctrl and wks_datapath; uses wks_pkg.
//
// Input items (s_axis_*) carry a function code and a target index: pick the
// next target by smooth weighted round-robin, report success, report failure,
// or a time tick. Every item yields one result item on m_axis_*: the picked
// target, a none-available flag and the count of healthy targets in use.
// The user writes configuration via cfg_we/cfg_index/cfg_data only while idle; not enforced.
//
// A pick visits one target per cycle through the shared scan datapath, then
// subtracts the total from the winner in the adjust step before the finish step
// loads the result register. Reports and ticks pass through the apply step before
// the finish step. A new item is accepted only in idle, after the previous item
// has left the finish step. The result register lets the next item be accepted
// while a result waits; if the receiver stalls, the following item holds before
// its result until the register frees. Reset restores the configuration defaults,
// marks all targets healthy and clears weights, failures and cooldowns.
`default_nettype none

module weighted_key_selector_with_health
  import wks_pkg::*;
#(
  parameter int NUM_TARGETS   = 8,
  parameter int WEIGHT_BITS   = 8,
  parameter int COOLDOWN_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,  // func[1:0], target_id[4:2], zero[7:5]
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [7:0]                 m_axis_tdata   // picked_target[2:0], none_available[3],
                                                    // healthy_total[7:4]
);

  cmd_t    cmd;
  status_t status;

  wks_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  wks_datapath #(
    .NUM_TARGETS   (NUM_TARGETS),
    .WEIGHT_BITS   (WEIGHT_BITS),
    .COOLDOWN_BITS (COOLDOWN_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

`default_nettype wire

### tb/sv/wks_result_checker.sv
// Result checker for the weighted key selector: follows every accepted item,
// keeps its own copy of health, weights and configuration, and checks results.
// Depends on wks_pkg for the function codes, register indexes and weight range.
module wks_result_checker
  import wks_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            in_data,   // func[1:0], target_id[4:2], zero[7:5]
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            out_data,  // picked_target[2:0], none_available[3],
                                           // healthy_total[7:4]
  output int                    errors,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TARGETS = 8;

  typedef struct packed {
    logic [3:0] healthy_total;
    logic       none_available;
    logic [2:0] picked_target;
  } selection_t;

  logic [63:0] weight_table;
  logic [3:0]  targets_in_use;
  logic [7:0]  failure_limit;
  logic [15:0] cooldown_ticks;

  logic signed [RW_W-1:0] run_weight [TARGETS];
  logic                   healthy    [TARGETS];
  logic [7:0]             fail_count [TARGETS];
  logic [15:0]            cool_left  [TARGETS];

  selection_t selections_due [$];

  function automatic logic signed [RW_W-1:0] clamp_weight(input int v);
    int c;
    c = v;
    if (c > int'(RW_MAX)) c = int'(RW_MAX);
    else if (c < int'(RW_MIN)) c = int'(RW_MIN);
    return c[RW_W-1:0];
  endfunction

  // a zero weight still counts as one
  function automatic int weight_of(input int idx);
    logic [7:0] w;
    w = weight_table[8*idx +: 8];
    return (w == 8'd0) ? 1 : int'(w);
  endfunction

  task automatic advance_selector(input func_t op, input logic [2:0] id,
                                  output selection_t res);
    int used, total, best, count, i;
    bit found;
    used = (targets_in_use > TARGETS) ? TARGETS : int'(targets_in_use);
    res = '0;
    case (op)
      FUNC_PICK: begin
        // revive expired targets before they compete
        for (i = 0; i < used; i++) begin
          if (!healthy[i] && cool_left[i] == 16'd0) begin
            healthy[i] = 1'b1;
            fail_count[i] = 8'd0;
            run_weight[i] = '0;
          end
        end
        total = 0;
        found = 1'b0;
        best = 0;
        for (i = 0; i < used; i++) begin
          if (healthy[i]) begin
            total += weight_of(i);
            run_weight[i] = clamp_weight(int'(run_weight[i]) + weight_of(i));
            if (!found || run_weight[i] > run_weight[best]) begin
              best = i;
              found = 1'b1;
            end
          end
        end
        if (found) begin
          run_weight[best] = clamp_weight(int'(run_weight[best]) - total);
          res.picked_target = best[2:0];
        end else begin
          res.none_available = 1'b1;
        end
      end
      FUNC_SUCCESS: begin
        if (id < used) begin
          fail_count[id] = 8'd0;
          healthy[id] = 1'b1;
        end
      end
      FUNC_FAILURE: begin
        if (id < used) begin
          if (fail_count[id] != 8'hFF) fail_count[id]++;
          if (fail_count[id] >= failure_limit) begin
            healthy[id] = 1'b0;
            cool_left[id] = cooldown_ticks;
          end
        end
      end
      FUNC_TICK: begin
        for (i = 0; i < TARGETS; i++) begin
          if (cool_left[i] != 16'd0) cool_left[i]--;
        end
      end
      default: ;
    endcase
    count = 0;
    for (i = 0; i < used; i++) begin
      if (healthy[i]) count++;
    end
    res.healthy_total = count[3:0];
  endtask

  always @(posedge clk) begin : watch
    selection_t got;
    selection_t want;
    if (rst) begin
      weight_table = '0;
      targets_in_use = 4'd8;
      failure_limit = 8'd3;
      cooldown_ticks = 16'd60;
      for (int i = 0; i < TARGETS; i++) begin
        run_weight[i] = '0;
        healthy[i] = 1'b1;
        fail_count[i] = 8'd0;
        cool_left[i] = 16'd0;
      end
      selections_due.delete();
      errors = 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_WEIGHT_TABLE:   weight_table = cfg_data[63:0];
          CFG_TARGETS_IN_USE: targets_in_use = cfg_data[3:0];
          CFG_FAILURE_LIMIT:  failure_limit = cfg_data[7:0];
          CFG_COOLDOWN_TICKS: cooldown_ticks = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        advance_selector(func_t'(in_data[1:0]), in_data[4:2], want);
        selections_due = {selections_due, want};
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (selections_due.size() == 0) begin
          if (errors < 10) $display("unexpected result item %h", out_data);
          errors++;
        end else begin
          want = selections_due.pop_front();
          if (got.picked_target !== want.picked_target ||
              got.none_available !== want.none_available ||
              got.healthy_total !== want.healthy_total) begin
            if (errors < 10) begin
              $display("result mismatch: picked %0d/%0d none %0b/%0b healthy %0d/%0d",
                       want.picked_target, got.picked_target,
                       want.none_available, got.none_available,
                       want.healthy_total, got.healthy_total);
            end
            errors++;
          end
        end
      end
      pending <= selections_due.size();
    end
  end

endmodule

### tb/sv/tb_weighted_key_selector_with_health.sv
// Top of the weighted key selector testbench: clock, reset, configuration
// phases and item traffic; wks_result_checker does the checking. Uses wks_pkg.
module tb_weighted_key_selector_with_health
  import wks_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT  = 600000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;  // func[1:0], target_id[4:2], zero[7:5]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;       // picked_target[2:0], none_available[3],
                                             // healthy_total[7:4]
  int   error_count;
  int   results_due;
  int   items_sent = 0;
  int   cur_used = 8;
  int   cur_limit = 3;
  int   cur_cool = 60;
  logic steady = 1'b0;

  weighted_key_selector_with_health i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  wks_result_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .errors    (error_count),
    .pending   (results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= steady || ($urandom_range(99) >= 29);
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic push_item(input func_t op, input logic [2:0] id);
    if (!steady && $urandom_range(99) < 29) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, id, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  // hold the input until every result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic configure(input logic [63:0] weights, input logic [3:0] used,
                           input logic [7:0] limit, input logic [15:0] cool);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WEIGHT_TABLE;
    cfg_data  <= weights;
    @(posedge clk);
    cfg_index <= CFG_TARGETS_IN_USE;
    cfg_data  <= {60'd0, used};
    @(posedge clk);
    cfg_index <= CFG_FAILURE_LIMIT;
    cfg_data  <= {56'd0, limit};
    @(posedge clk);
    cfg_index <= CFG_COOLDOWN_TICKS;
    cfg_data  <= {48'd0, cool};
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_used  = (used > 4'd8) ? 8 : int'(used);
    cur_limit = int'(limit);
    cur_cool  = int'(cool);
  endtask

  function automatic logic [2:0] target_for(input int used);
    logic [2:0] t;
    if (used > 0 && $urandom_range(4) != 0) t = 3'($urandom_range(used - 1));
    else t = 3'($urandom_range(7));
    return t;
  endfunction

  function automatic func_t random_func();
    int r;
    r = $urandom_range(99);
    if (r < 40) return FUNC_PICK;
    if (r < 50) return FUNC_SUCCESS;
    if (r < 78) return FUNC_FAILURE;
    return FUNC_TICK;
  endfunction

  task automatic run_phase(input int budget);
    int start, kind, k;
    logic [2:0] id;
    start = items_sent;
    while (items_sent - start < budget) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        push_item(random_func(), target_for(cur_used));
      end else if (kind < 75) begin
        // fail one target up to six times, tick down its cooldown (fully only when short), then pick again
        id = target_for(cur_used);
        k = cur_limit + $urandom_range(1);
        if (k < 1) k = 1;
        if (k > 6) k = 6;
        repeat (k) push_item(FUNC_FAILURE, id);
        k = (cur_cool < 12) ? cur_cool + $urandom_range(1) : $urandom_range(3);
        repeat (k) push_item(FUNC_TICK, 3'($urandom_range(7)));
        push_item(FUNC_PICK, 3'($urandom_range(7)));
        if ($urandom_range(3) == 0) push_item(FUNC_SUCCESS, id);
      end else begin
        repeat ($urandom_range(2, 6)) push_item(FUNC_PICK, 3'($urandom_range(7)));
      end
      if ($urandom_range(99) == 0) drain();
    end
  endtask

  initial begin : stimulus
    int base, phase;
    logic [63:0] w;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: every weight counts as one, three failures to drop
    push_item(FUNC_PICK, 3'd0);
    push_item(FUNC_PICK, 3'd7);
    push_item(FUNC_PICK, 3'd5);
    repeat (3) push_item(FUNC_FAILURE, 3'd0);
    push_item(FUNC_PICK, 3'd0);
    push_item(FUNC_SUCCESS, 3'd0);
    push_item(FUNC_TICK, 3'd2);
    drain();

    // three targets, drop on every failure, short cooldown
    configure(64'hFF01_0203_7F80_FE00, 4'd3, 8'd0, 16'd2);
    push_item(FUNC_PICK, 3'd0);
    push_item(FUNC_FAILURE, 3'd5);
    push_item(FUNC_FAILURE, 3'd1);
    push_item(FUNC_FAILURE, 3'd1);
    push_item(FUNC_PICK, 3'd0);
    push_item(FUNC_TICK, 3'd0);
    push_item(FUNC_TICK, 3'd0);
    push_item(FUNC_PICK, 3'd0);
    push_item(FUNC_FAILURE, 3'd0);
    push_item(FUNC_FAILURE, 3'd1);
    push_item(FUNC_FAILURE, 3'd2);
    push_item(FUNC_PICK, 3'd0);
    push_item(FUNC_SUCCESS, 3'd2);
    push_item(FUNC_SUCCESS, 3'd2);
    push_item(FUNC_PICK, 3'd0);
    drain();

    // no targets at all
    configure(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 8'd1, 16'd0);
    push_item(FUNC_PICK, 3'd0);
    push_item(FUNC_SUCCESS, 3'd0);
    push_item(FUNC_FAILURE, 3'd0);
    push_item(FUNC_TICK, 3'd0);
    drain();

    // more targets than exist, largest limit and cooldown
    configure({$urandom, $urandom}, 4'd15, 8'd255, 16'hFFFF);
    push_item(FUNC_PICK, 3'd7);
    push_item(FUNC_PICK, 3'd7);

    base = items_sent;
    phase = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      drain();
      steady <= (phase % 8 == 4);
      w = {$urandom, $urandom};
      case (phase % 8)
        0: configure(w, 4'd8, 8'($urandom_range(1, 4)), 16'($urandom_range(0, 5)));
        1: configure(64'd0, 4'd8, 8'd0, 16'd0);
        2: begin
          configure(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 8'd255, 16'd3);
          // run the failure count into its ceiling
          repeat (258) push_item(FUNC_FAILURE, 3'd1);
          repeat (5) push_item(FUNC_TICK, 3'd1);
          push_item(FUNC_PICK, 3'd1);
        end
        3: configure(w, 4'($urandom_range(0, 15)), 8'($urandom_range(1, 4)), 16'hFFFF);
        4: configure(w, 4'd1, 8'd2, 16'd1);
        5: begin
          for (int b = 0; b < 8; b++) begin
            if ($urandom_range(2) == 0) w[8*b +: 8] = 8'd0;
          end
          configure(w, 4'($urandom_range(9, 15)), 8'($urandom_range(1, 3)),
                    16'($urandom_range(0, 8)));
        end
        6: configure(w, 4'd0, 8'd3, 16'd4);
        default: configure(w, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 7)),
                           16'($urandom_range(0, 10)));
      endcase
      run_phase(160);
      phase++;
    end

    drain();
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/wks_pkg.sv
rtl/wks_ctrl.sv
rtl/wks_datapath.sv
rtl/weighted_key_selector_with_health.sv
tb/sv/wks_result_checker.sv
tb/sv/tb_weighted_key_selector_with_health.sv
